// ----- sv/assert_macros.svh -----
// Assertion shorthands shared by the RTL of the display interface sequencer.
// Each macro wraps one concurrent assertion clocked on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define CLCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define CLCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/clcd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and power-up tables for the display interface sequencer.
// No dependencies; every other file of the block refers to it by scoped name.
package clcd_pkg;

  localparam int COUNTER_WIDTH = 16;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_INDEX_W   = 2;
  localparam int INIT_LAST     = 11;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE_WAIT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLEAR_WAIT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_POWER_WAIT  = 2'd2;

  localparam logic [7:0]  SETTLE_WAIT_RESET = 8'd50;
  localparam logic [11:0] CLEAR_WAIT_RESET  = 12'd1650;
  localparam logic [15:0] POWER_WAIT_RESET  = 16'd20000;

  // Function codes of the input word.
  localparam logic [2:0] FUNC_TICK     = 3'd0;
  localparam logic [2:0] FUNC_INSTR    = 3'd1;
  localparam logic [2:0] FUNC_CHAR     = 3'd2;
  localparam logic [2:0] FUNC_POSITION = 3'd3;
  localparam logic [2:0] FUNC_CLEAR    = 3'd4;
  localparam logic [2:0] FUNC_HOME     = 3'd5;
  localparam logic [2:0] FUNC_INIT     = 3'd6;

  localparam logic [7:0] LINE1_BASE = 8'h80;
  localparam logic [7:0] LINE2_BASE = 8'hC0;
  localparam logic [7:0] CMD_CLEAR  = 8'h01;
  localparam logic [7:0] CMD_HOME   = 8'h02;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] byte_value;
    logic       line_select;
    logic [5:0] column;
    logic [3:0] bus_nibble;
  } in_word_t;

  typedef struct packed {
    logic       enable_pin;
    logic       select_pin;
    logic       read_pin;
    logic [3:0] data_nibble;
    logic       drive_enable;
    logic       power_pin;
    logic       ready_res;
    logic       command_refused;
  } out_word_t;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_INIT  = 2'd2
  } cmd_kind_t;

  // A classified word as it waits in the queue.
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] wr_byte;
    logic       wr_select;
    logic       wr_extra;
    logic [3:0] bus_nibble;
  } cmd_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
    logic              full;
  } q_status_t;

  // Nibbles of the power-up sequence, including 0x28, 0x01, 0x0C and 0x06.
  function automatic logic [3:0] init_nibble(input logic [3:0] idx);
    logic [3:0] nib;
    unique case (idx)
      4'd0, 4'd1, 4'd2: nib = 4'h3;
      4'd3, 4'd4:       nib = 4'h2;
      4'd5:             nib = 4'h8;
      4'd7:             nib = 4'h1;
      4'd9:             nib = 4'hC;
      4'd11:            nib = 4'h6;
      default:          nib = 4'h0;
    endcase
    return nib;
  endfunction

  // Wait after each power-up nibble, in microseconds.
  function automatic logic [15:0] init_wait(input logic [3:0] idx);
    logic [15:0] w;
    unique case (idx)
      4'd0, 4'd7: w = 16'd5000;
      4'd1:       w = 16'd200;
      default:    w = 16'd80;
    endcase
    return w;
  endfunction

endpackage

// ----- sv/char_lcd_4bit_interface_sequencer.sv -----
`timescale 1ns / 1ps
// Character display 4-bit interface sequencer, top level. Depends on clcd_pkg,
// clcd_front, clcd_queue, clcd_back and assert_macros.svh.
//
// Each input word is one microsecond tick and yields exactly one output word
// that gives the display pin levels for the coming microsecond, together with
// the ready and refused flags. The block sustains one word per clock while the
// receiver does not stall: the front end decodes a word in the cycle it is
// accepted and places it in a two-entry queue, and the back end runs one
// sequencer step per cycle and registers the resulting word, so a word passes
// through a queue slot and then the output register. The front stalls only
// when the queue is full, and the back only when its output register is held
// by a stalled receiver, so each side can stall on its own. Configuration
// registers are written through a plain write port and should be changed only
// while the block is idle.
`include "assert_macros.svh"

module char_lcd_4bit_interface_sequencer #(
  parameter int COUNTER_WIDTH = clcd_pkg::COUNTER_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  clcd_pkg::in_word_t                  in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output clcd_pkg::out_word_t                 out_word,
  input  logic                                cfg_we,
  input  logic [clcd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [clcd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int QD = clcd_pkg::QUEUE_DEPTH;

  logic                q_push;
  logic                q_pop;
  clcd_pkg::cmd_t      q_in_cmd;
  clcd_pkg::cmd_t      q_head_cmd;
  clcd_pkg::q_status_t q_stat;

  // Front end: decode the function code into a command and queue it.
  clcd_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_full   (q_stat.full),
    .push     (q_push),
    .push_cmd (q_in_cmd)
  );

  // Decoupling queue between the two halves.
  clcd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .pop      (q_pop),
    .head_cmd (q_head_cmd),
    .status   (q_stat)
  );

  // Back end: the timed pin sequencer and the output register.
  clcd_back #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head_cmd  (q_head_cmd),
    .q_empty   (q_stat.empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // The back end only takes a word that is really waiting in the queue.
  `CLCD_ASSERT(a_pop_not_empty, q_pop |-> !q_stat.empty, "pop from an empty queue")
  // The front end never pushes into a full queue.
  `CLCD_ASSERT(a_push_not_full, q_push |-> !q_stat.full, "push into a full queue")
  // The queue fill never exceeds its depth.
  `CLCD_ASSERT(a_count_bound, q_stat.count <= QD, "queue fill beyond its depth")
  // Reset leaves no word pending at the output.
  `CLCD_ASSERT_ALWAYS(a_reset_clears_out, rst |=> !out_valid, "output valid after reset")

endmodule

// ----- sv/clcd_front.sv -----
`timescale 1ns / 1ps
// Front end: takes input words, decodes the function code and pushes the
// classified command into the queue. Depends on clcd_pkg.
module clcd_front (
  input  logic                in_valid,
  output logic                in_stall,
  input  clcd_pkg::in_word_t  in_word,
  input  logic                q_full,
  output logic                push,
  output clcd_pkg::cmd_t      push_cmd
);

  logic [7:0] pos_addr;

  // Cursor address wraps modulo 256, so column zero lands just below the base.
  assign pos_addr = (in_word.line_select ? clcd_pkg::LINE2_BASE : clcd_pkg::LINE1_BASE)
                    + {2'b00, in_word.column} - 8'd1;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_cmd            = '0;
    push_cmd.kind       = clcd_pkg::KIND_TICK;
    push_cmd.bus_nibble = in_word.bus_nibble;
    unique case (in_word.func)
      clcd_pkg::FUNC_INSTR: begin
        push_cmd.kind    = clcd_pkg::KIND_WRITE;
        push_cmd.wr_byte = in_word.byte_value;
      end
      clcd_pkg::FUNC_CHAR: begin
        push_cmd.kind      = clcd_pkg::KIND_WRITE;
        push_cmd.wr_byte   = in_word.byte_value;
        push_cmd.wr_select = 1'b1;
      end
      clcd_pkg::FUNC_POSITION: begin
        push_cmd.kind    = clcd_pkg::KIND_WRITE;
        push_cmd.wr_byte = pos_addr;
      end
      clcd_pkg::FUNC_CLEAR: begin
        push_cmd.kind     = clcd_pkg::KIND_WRITE;
        push_cmd.wr_byte  = clcd_pkg::CMD_CLEAR;
        push_cmd.wr_extra = 1'b1;
      end
      clcd_pkg::FUNC_HOME: begin
        push_cmd.kind     = clcd_pkg::KIND_WRITE;
        push_cmd.wr_byte  = clcd_pkg::CMD_HOME;
        push_cmd.wr_extra = 1'b1;
      end
      clcd_pkg::FUNC_INIT: begin
        push_cmd.kind = clcd_pkg::KIND_INIT;
      end
      default: begin
        push_cmd.kind = clcd_pkg::KIND_TICK;
      end
    endcase
  end

endmodule

// ----- sv/clcd_queue.sv -----
`timescale 1ns / 1ps
// Short first-in first-out queue of classified commands between the front
// and back ends. Depends on clcd_pkg.
module clcd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  clcd_pkg::cmd_t        push_cmd,
  input  logic                  pop,
  output clcd_pkg::cmd_t        head_cmd,
  output clcd_pkg::q_status_t   status
);

  localparam logic [clcd_pkg::QPTR_W-1:0] LAST_SLOT =
    clcd_pkg::QPTR_W'(clcd_pkg::QUEUE_DEPTH - 1);
  localparam logic [clcd_pkg::QCNT_W-1:0] FULL_COUNT =
    clcd_pkg::QCNT_W'(clcd_pkg::QUEUE_DEPTH);

  clcd_pkg::cmd_t                slots [clcd_pkg::QUEUE_DEPTH];
  logic [clcd_pkg::QPTR_W-1:0]   wr_ptr;
  logic [clcd_pkg::QPTR_W-1:0]   rd_ptr;
  logic [clcd_pkg::QCNT_W-1:0]   count;

  assign head_cmd     = slots[rd_ptr];
  assign status.count = count;
  assign status.empty = (count == '0);
  assign status.full  = (count == FULL_COUNT);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/clcd_back.sv -----
`timescale 1ns / 1ps
// Back end: the microsecond sequencer that drives the display pins, the
// configuration registers and the output register. Depends on clcd_pkg.
module clcd_back #(
  parameter int COUNTER_WIDTH = clcd_pkg::COUNTER_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [clcd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [clcd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  clcd_pkg::cmd_t                      head_cmd,
  input  logic                                q_empty,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output clcd_pkg::out_word_t                 out_word
);

  localparam int CW = COUNTER_WIDTH;
  localparam int WW = (CW > 16) ? CW : 16;

  typedef enum logic [12:0] {
    ST_IDLE       = 13'b0000000000001,
    ST_POWER      = 13'b0000000000010,
    ST_INIT_PULSE = 13'b0000000000100,
    ST_INIT_WAIT  = 13'b0000000001000,
    ST_FPOLL_HI   = 13'b0000000010000,
    ST_FPOLL_LO   = 13'b0000000100000,
    ST_POLL_HI    = 13'b0000001000000,
    ST_POLL_LO    = 13'b0000010000000,
    ST_HI_PULSE   = 13'b0000100000000,
    ST_HI_WAIT    = 13'b0001000000000,
    ST_LO_PULSE   = 13'b0010000000000,
    ST_LO_WAIT    = 13'b0100000000000,
    ST_EXTRA      = 13'b1000000000000
  } seq_state_t;

  // Pin register layout: data nibble, E, RS, RW, power.
  localparam int PIN_E   = 4;
  localparam int PIN_RS  = 5;
  localparam int PIN_RW  = 6;
  localparam int PIN_PWR = 7;

  seq_state_t      state, state_next;
  logic [3:0]      init_idx, init_idx_next;
  logic [CW-1:0]   counter, counter_next;
  logic [7:0]      pend_byte, pend_byte_next;
  logic            pend_sel, pend_sel_next;
  logic            pend_extra, pend_extra_next;
  logic [7:0]      pins, pins_next;
  logic [7:0]      settle_wait;
  logic [11:0]     clear_wait;
  logic [15:0]     power_wait;

  logic [CW-1:0]   cnt_dec;
  logic            done;
  logic            refused;
  clcd_pkg::out_word_t word_next;

  // Zero waits last one tick; waits beyond the counter saturate.
  function automatic logic [CW-1:0] clamp_wait(input logic [15:0] w);
    logic [WW-1:0] wx;
    logic [CW-1:0] r;
    wx = WW'(w);
    if (w == 16'd0) begin
      r = CW'(1);
    end else if (wx > WW'({CW{1'b1}})) begin
      r = '1;
    end else begin
      r = CW'(wx);
    end
    return r;
  endfunction

  assign pop     = !q_empty && (!out_valid || !out_stall);
  assign cnt_dec = (counter != '0) ? counter - 1'b1 : '0;
  assign done    = (cnt_dec == '0);

  always_comb begin
    state_next      = state;
    init_idx_next   = init_idx;
    counter_next    = counter;
    pend_byte_next  = pend_byte;
    pend_sel_next   = pend_sel;
    pend_extra_next = pend_extra;
    pins_next       = pins;
    refused         = 1'b0;

    if (state == ST_IDLE) begin
      unique case (head_cmd.kind)
        clcd_pkg::KIND_WRITE: begin
          pend_byte_next  = head_cmd.wr_byte;
          pend_sel_next   = head_cmd.wr_select;
          pend_extra_next = head_cmd.wr_extra;
          pins_next       = {pins[PIN_PWR], 1'b1, 1'b0, 1'b1, pins[3:0]};
          counter_next    = '0;
          state_next      = ST_POLL_HI;
        end
        clcd_pkg::KIND_INIT: begin
          pins_next    = 8'h80;
          counter_next = clamp_wait(power_wait);
          state_next   = ST_POWER;
        end
        default: begin
        end
      endcase
    end else begin
      refused = (head_cmd.kind != clcd_pkg::KIND_TICK);
      unique case (state)
        ST_POWER: begin
          counter_next = cnt_dec;
          if (done) begin
            init_idx_next = 4'd0;
            pins_next     = {pins[PIN_PWR], 3'b001, clcd_pkg::init_nibble(4'd0)};
            counter_next  = CW'(2);
            state_next    = ST_INIT_PULSE;
          end
        end
        ST_INIT_PULSE: begin
          counter_next = cnt_dec;
          if (done) begin
            pins_next[PIN_E] = 1'b0;
            counter_next     = clamp_wait(clcd_pkg::init_wait(init_idx));
            state_next       = ST_INIT_WAIT;
          end
        end
        ST_INIT_WAIT: begin
          counter_next = cnt_dec;
          if (done) begin
            if (init_idx != 4'(clcd_pkg::INIT_LAST)) begin
              init_idx_next = init_idx + 4'd1;
              pins_next     = {pins[PIN_PWR], 3'b001,
                               clcd_pkg::init_nibble(init_idx + 4'd1)};
              counter_next  = CW'(2);
              state_next    = ST_INIT_PULSE;
            end else begin
              pins_next    = {pins[PIN_PWR], 1'b1, 1'b0, 1'b1, pins[3:0]};
              counter_next = '0;
              state_next   = ST_FPOLL_HI;
            end
          end
        end
        ST_FPOLL_HI, ST_POLL_HI: begin
          // Counter holds the sampled busy flag for the low half of the poll.
          pins_next[PIN_E] = 1'b0;
          counter_next     = CW'(head_cmd.bus_nibble[3]);
          state_next       = (state == ST_FPOLL_HI) ? ST_FPOLL_LO : ST_POLL_LO;
        end
        ST_FPOLL_LO: begin
          if (counter != '0) begin
            pins_next    = {pins[PIN_PWR], 1'b1, 1'b0, 1'b1, pins[3:0]};
            counter_next = '0;
            state_next   = ST_FPOLL_HI;
          end else begin
            pins_next[PIN_E] = 1'b0;
            counter_next     = '0;
            state_next       = ST_IDLE;
          end
        end
        ST_POLL_LO: begin
          if (counter != '0) begin
            pins_next    = {pins[PIN_PWR], 1'b1, 1'b0, 1'b1, pins[3:0]};
            counter_next = '0;
            state_next   = ST_POLL_HI;
          end else begin
            pins_next    = {pins[PIN_PWR], 1'b0, pend_sel, 1'b1, pend_byte[7:4]};
            counter_next = CW'(2);
            state_next   = ST_HI_PULSE;
          end
        end
        ST_HI_PULSE: begin
          counter_next = cnt_dec;
          if (done) begin
            pins_next[PIN_E] = 1'b0;
            counter_next     = clamp_wait({8'd0, settle_wait});
            state_next       = ST_HI_WAIT;
          end
        end
        ST_HI_WAIT: begin
          counter_next = cnt_dec;
          if (done) begin
            pins_next    = {pins[PIN_PWR], 1'b0, pend_sel, 1'b1, pend_byte[3:0]};
            counter_next = CW'(2);
            state_next   = ST_LO_PULSE;
          end
        end
        ST_LO_PULSE: begin
          counter_next = cnt_dec;
          if (done) begin
            pins_next[PIN_E] = 1'b0;
            counter_next     = clamp_wait({8'd0, settle_wait});
            state_next       = ST_LO_WAIT;
          end
        end
        ST_LO_WAIT: begin
          counter_next = cnt_dec;
          if (done) begin
            pins_next[PIN_E] = 1'b0;
            if (pend_extra) begin
              counter_next = clamp_wait({4'd0, clear_wait});
              state_next   = ST_EXTRA;
            end else begin
              counter_next = '0;
              state_next   = ST_IDLE;
            end
          end
        end
        ST_EXTRA: begin
          counter_next = cnt_dec;
          if (done) begin
            pins_next[PIN_E] = 1'b0;
            counter_next     = '0;
            state_next       = ST_IDLE;
          end
        end
        default: begin
          pins_next[PIN_E] = 1'b0;
          counter_next     = '0;
          state_next       = ST_IDLE;
        end
      endcase
    end

    word_next.enable_pin      = pins_next[PIN_E];
    word_next.select_pin      = pins_next[PIN_RS];
    word_next.read_pin        = pins_next[PIN_RW];
    word_next.data_nibble     = pins_next[3:0];
    word_next.drive_enable    = pins_next[PIN_PWR] && !pins_next[PIN_RW];
    word_next.power_pin       = pins_next[PIN_PWR];
    word_next.ready_res       = (state_next == ST_IDLE);
    word_next.command_refused = refused;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_wait <= clcd_pkg::SETTLE_WAIT_RESET;
      clear_wait  <= clcd_pkg::CLEAR_WAIT_RESET;
      power_wait  <= clcd_pkg::POWER_WAIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        clcd_pkg::CFG_SETTLE_WAIT: settle_wait <= cfg_data[7:0];
        clcd_pkg::CFG_CLEAR_WAIT:  clear_wait  <= cfg_data[11:0];
        clcd_pkg::CFG_POWER_WAIT:  power_wait  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      init_idx   <= '0;
      counter    <= '0;
      pend_byte  <= '0;
      pend_sel   <= 1'b0;
      pend_extra <= 1'b0;
      pins       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        state      <= state_next;
        init_idx   <= init_idx_next;
        counter    <= counter_next;
        pend_byte  <= pend_byte_next;
        pend_sel   <= pend_sel_next;
        pend_extra <= pend_extra_next;
        pins       <= pins_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_word <= word_next;
    end
  end

endmodule

// ----- verif/char_lcd_4bit_interface_sequencer_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the 4-bit character display sequencer. It feeds microsecond
// tick words, predicts every output word in order and compares them field by field.
// Depends on clcd_pkg and char_lcd_4bit_interface_sequencer.
module char_lcd_4bit_interface_sequencer_tb;
  import clcd_pkg::*;

  // Function code 7 is unused by the block and must behave as a plain tick.
  localparam logic [2:0] FUNC_SPARE = 3'd7;
  localparam int unsigned CNT_TOP = (1 << COUNTER_WIDTH) - 1;
  localparam int MAX_OUTSTANDING = 3;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int RAND_PHASE_WORDS = 120;
  localparam int FINAL_IDLING_WORDS = 120;
  localparam int FINAL_STEADY_WORDS = 80;
  localparam int IDLE_REROLL = 300;

  // Power-up nibbles and the waits that follow them, entry 0 in the lowest slice:
  // 3, 3, 3, 2, then 0x28, 0x01, 0x0C and 0x06 as high and low nibbles.
  localparam logic [47:0] PWRUP_NIBBLES = 48'h60C0_1082_2333;
  localparam logic [191:0] PWRUP_WAITS = {16'd80, 16'd80, 16'd80, 16'd80, 16'd5000, 16'd80,
                                          16'd80, 16'd80, 16'd80, 16'd80, 16'd200, 16'd5000};

  typedef enum logic [3:0] {
    STEP_IDLE, STEP_POWER, STEP_INIT_PULSE, STEP_INIT_WAIT, STEP_FPOLL_HI, STEP_FPOLL_LO,
    STEP_POLL_HI, STEP_POLL_LO, STEP_HI_PULSE, STEP_HI_WAIT, STEP_LO_PULSE, STEP_LO_WAIT,
    STEP_EXTRA
  } lcd_step_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_word_t               in_word = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_word_t              out_word;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  char_lcd_4bit_interface_sequencer u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Predicted sequencer state. It starts in the reset state, since reset is applied
  // only once, before any word is offered.
  lcd_step_t   seq_step = STEP_IDLE;
  int unsigned init_idx = 0;
  int unsigned dly = 0;
  logic [7:0]  pend_byte = '0;
  logic        pend_rs = 1'b0;
  logic        pend_extra = 1'b0;
  logic        lcd_e = 1'b0;
  logic        lcd_rs = 1'b0;
  logic        lcd_rw = 1'b0;
  logic        lcd_pwr = 1'b0;
  logic [3:0]  lcd_data = '0;

  // Shadow copies of the wait registers.
  logic [7:0]  settle_us = SETTLE_WAIT_RESET;
  logic [11:0] clear_us = CLEAR_WAIT_RESET;
  logic [15:0] power_us = POWER_WAIT_RESET;

  in_word_t  pending_words[$];
  out_word_t expected_pins[$];
  int words_pushed = 0;
  int words_taken = 0;
  int words_checked = 0;
  int mismatch_count = 0;
  int cmds_sent = 0;
  int refused_count = 0;
  int powerups = 0;
  int reg_writes = 0;

  bit word_taken = 1'b0;
  bit idling_on = 1'b1;
  bit long_hold_ask = 1'b0;
  int send_gap = 0;
  int hold_left = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  int send_cycles = 0;
  int recv_cycles = 0;

  // A wait of zero still lasts one tick, and nothing may exceed the counter.
  function automatic int unsigned clamp_us(input int unsigned us);
    if (us == 0) return 1;
    if (us > CNT_TOP) return CNT_TOP;
    return us;
  endfunction

  function automatic void lcd_pulse(input lcd_step_t nxt, input logic rs, input logic [3:0] nib);
    lcd_e    = 1'b1;
    lcd_rs   = rs;
    lcd_rw   = 1'b0;
    lcd_data = nib;
    dly      = 2;
    seq_step = nxt;
  endfunction

  function automatic void lcd_settle(input lcd_step_t nxt, input int unsigned us);
    lcd_e    = 1'b0;
    dly      = clamp_us(us);
    seq_step = nxt;
  endfunction

  // A busy poll keeps the data latch but releases the pins for reading.
  function automatic void lcd_poll(input lcd_step_t nxt);
    lcd_e    = 1'b1;
    lcd_rw   = 1'b1;
    lcd_rs   = 1'b0;
    dly      = 0;
    seq_step = nxt;
  endfunction

  function automatic void lcd_park();
    lcd_e    = 1'b0;
    dly      = 0;
    seq_step = STEP_IDLE;
  endfunction

  // True once the current timed step has run out.
  function automatic bit tick_down();
    if (dly > 0) dly--;
    return dly == 0;
  endfunction

  function automatic void lcd_start_write(input logic [7:0] value, input logic rs,
                                          input logic extra);
    pend_byte  = value;
    pend_rs    = rs;
    pend_extra = extra;
    lcd_poll(STEP_POLL_HI);
  endfunction

  function automatic void lcd_advance(input logic [3:0] bus);
    case (seq_step)
      STEP_POWER: begin
        if (tick_down()) begin
          init_idx = 0;
          lcd_pulse(STEP_INIT_PULSE, 1'b0, PWRUP_NIBBLES[3:0]);
        end
      end
      STEP_INIT_PULSE: begin
        if (tick_down()) lcd_settle(STEP_INIT_WAIT, PWRUP_WAITS[init_idx*16 +: 16]);
      end
      STEP_INIT_WAIT: begin
        if (tick_down()) begin
          if (init_idx < INIT_LAST) begin
            init_idx++;
            lcd_pulse(STEP_INIT_PULSE, 1'b0, PWRUP_NIBBLES[init_idx*4 +: 4]);
          end else begin
            lcd_poll(STEP_FPOLL_HI);
          end
        end
      end
      // The poll strobe ends; the busy flag is bit 3 of what the display answered.
      STEP_FPOLL_HI, STEP_POLL_HI: begin
        lcd_e    = 1'b0;
        dly      = bus[3];
        seq_step = (seq_step == STEP_FPOLL_HI) ? STEP_FPOLL_LO : STEP_POLL_LO;
      end
      STEP_FPOLL_LO: begin
        if (dly != 0) lcd_poll(STEP_FPOLL_HI);
        else lcd_park();
      end
      STEP_POLL_LO: begin
        if (dly != 0) lcd_poll(STEP_POLL_HI);
        else lcd_pulse(STEP_HI_PULSE, pend_rs, pend_byte[7:4]);
      end
      STEP_HI_PULSE: begin
        if (tick_down()) lcd_settle(STEP_HI_WAIT, settle_us);
      end
      STEP_HI_WAIT: begin
        if (tick_down()) lcd_pulse(STEP_LO_PULSE, pend_rs, pend_byte[3:0]);
      end
      STEP_LO_PULSE: begin
        if (tick_down()) lcd_settle(STEP_LO_WAIT, settle_us);
      end
      STEP_LO_WAIT: begin
        if (tick_down()) begin
          if (pend_extra) lcd_settle(STEP_EXTRA, clear_us);
          else lcd_park();
        end
      end
      STEP_EXTRA: begin
        if (tick_down()) lcd_park();
      end
      default: lcd_park();
    endcase
  endfunction

  // Works out the output word that one accepted tick word produces.
  function automatic out_word_t lcd_next(input in_word_t w);
    out_word_t  o;
    logic [7:0] addr;
    logic       refused;
    refused = 1'b0;
    if (seq_step == STEP_IDLE) begin
      case (w.func)
        FUNC_INSTR: lcd_start_write(w.byte_value, 1'b0, 1'b0);
        FUNC_CHAR:  lcd_start_write(w.byte_value, 1'b1, 1'b0);
        FUNC_POSITION: begin
          // The address wraps modulo 256, so column 0 lands just below the line base.
          addr = (w.line_select ? LINE2_BASE : LINE1_BASE) + {2'b00, w.column} - 8'd1;
          lcd_start_write(addr, 1'b0, 1'b0);
        end
        FUNC_CLEAR: lcd_start_write(CMD_CLEAR, 1'b0, 1'b1);
        FUNC_HOME:  lcd_start_write(CMD_HOME, 1'b0, 1'b1);
        FUNC_INIT: begin
          lcd_e    = 1'b0;
          lcd_rs   = 1'b0;
          lcd_rw   = 1'b0;
          lcd_data = '0;
          lcd_pwr  = 1'b1;
          dly      = clamp_us(power_us);
          seq_step = STEP_POWER;
        end
        default: ;
      endcase
    end else begin
      refused = (w.func >= FUNC_INSTR) && (w.func <= FUNC_INIT);
      lcd_advance(w.bus_nibble);
    end
    o.enable_pin      = lcd_e;
    o.select_pin      = lcd_rs;
    o.read_pin        = lcd_rw;
    o.data_nibble     = lcd_data;
    o.drive_enable    = lcd_pwr & ~lcd_rw;
    o.power_pin       = lcd_pwr;
    o.ready_res       = (seq_step == STEP_IDLE);
    o.command_refused = refused;
    return o;
  endfunction

  function automatic void check_field(input string name, input logic [3:0] want,
                                      input logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Input side of the handshake: a word is taken at the rising edge, predicted at the
  // following falling edge, and the next pending word (or a gap) is put up then.
  always @(negedge clk) begin : word_driver
    out_word_t want;
    send_cycles++;
    if (send_cycles % IDLE_REROLL == 0) send_calm = ($urandom_range(0, 3) == 0);
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (word_taken) begin
        want = lcd_next(in_word);
        if (want.command_refused) refused_count++;
        expected_pins.push_back(want);
        words_taken++;
      end
      // A word still waiting for acceptance is held unchanged.
      if (!in_valid || word_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (idling_on && !send_calm && $urandom_range(0, 19) == 0) begin
          send_gap = $urandom_range(0, 17);
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_word  <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiving side: short random stall bursts, plus a long hold-off on each request that
  // lets the block fill up and push back on its input.
  always @(negedge clk) begin
    recv_cycles++;
    if (recv_cycles % IDLE_REROLL == 0) recv_calm = ($urandom_range(0, 3) == 0);
    if (rst) begin
      out_stall <= 1'b0;
    end else if (long_hold_ask) begin
      long_hold_ask <= 1'b0;
      hold_left = LONG_HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (idling_on && !recv_calm && $urandom_range(0, 19) == 0) begin
      hold_left = $urandom_range(0, 17);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Both handshakes are sampled here at the rising edge.
  always @(posedge clk) begin : pin_check
    out_word_t want;
    word_taken <= !rst && in_valid && !in_stall;
    if (!rst && out_valid && !out_stall) begin
      if (expected_pins.size() == 0) begin
        $error("output word arrived with no prediction waiting");
        mismatch_count++;
      end else begin
        want = expected_pins.pop_front();
        check_field("enable_pin", want.enable_pin, out_word.enable_pin);
        check_field("select_pin", want.select_pin, out_word.select_pin);
        check_field("read_pin", want.read_pin, out_word.read_pin);
        check_field("data_nibble", want.data_nibble, out_word.data_nibble);
        check_field("drive_enable", want.drive_enable, out_word.drive_enable);
        check_field("power_pin", want.power_pin, out_word.power_pin);
        check_field("ready_res", want.ready_res, out_word.ready_res);
        check_field("command_refused", want.command_refused, out_word.command_refused);
      end
      words_checked <= words_checked + 1;
    end
  end

  // Keeps only a few words ahead of the predictor, so that its state stays close to
  // the state in which those words will be taken.
  task automatic send_word(input in_word_t w);
    while (words_pushed - words_taken >= MAX_OUTSTANDING) @(posedge clk);
    pending_words.push_back(w);
    words_pushed++;
  endtask

  // A tick with random content. Deep inside a long wait a command is sometimes slipped
  // in; the margin on the counter guarantees that it meets a busy block.
  function automatic in_word_t filler_word();
    in_word_t w;
    w.func        = ($urandom_range(0, 7) == 0) ? FUNC_SPARE : FUNC_TICK;
    w.byte_value  = 8'($urandom);
    w.line_select = 1'($urandom_range(0, 1));
    w.column      = 6'($urandom_range(0, 63));
    w.bus_nibble  = {($urandom_range(0, 3) == 0), 3'($urandom_range(0, 7))};
    if (seq_step != STEP_IDLE && dly > words_pushed - words_taken + 3 &&
        $urandom_range(0, 15) == 0)
      w.func = 3'($urandom_range(FUNC_INSTR, FUNC_INIT));
    return w;
  endfunction

  // Feeds ticks until every word has been taken and the sequencer is back at idle.
  task automatic finish_sequence();
    while (words_pushed != words_taken || seq_step != STEP_IDLE) begin
      if (seq_step != STEP_IDLE) send_word(filler_word());
      else @(posedge clk);
    end
  endtask

  task automatic issue(input logic [2:0] func, input logic [7:0] value, input logic lsel,
                       input logic [5:0] col);
    in_word_t w;
    finish_sequence();
    w.func        = func;
    w.byte_value  = value;
    w.line_select = lsel;
    w.column      = col;
    w.bus_nibble  = 4'($urandom_range(0, 15));
    send_word(w);
    cmds_sent++;
    if (func == FUNC_INIT) powerups++;
    finish_sequence();
  endtask

  // Starts the power-up sequence from idle. Its fixed waits run far past the end of the
  // run, so the block stays busy from here on.
  task automatic start_power_up();
    in_word_t w;
    finish_sequence();
    w            = '0;
    w.func       = FUNC_INIT;
    w.bus_nibble = 4'($urandom_range(0, 15));
    send_word(w);
    cmds_sent++;
    powerups++;
  endtask

  task automatic random_command();
    logic [2:0] func;
    logic [5:0] col;
    int         pick;
    pick = $urandom_range(0, 19);
    if (pick < 5) func = FUNC_INSTR;
    else if (pick < 10) func = FUNC_CHAR;
    else if (pick < 14) func = FUNC_POSITION;
    else if (pick < 16) func = FUNC_CLEAR;
    else if (pick < 18) func = FUNC_HOME;
    else if (pick < 19) func = FUNC_TICK;
    else func = FUNC_SPARE;
    // Mostly real columns, now and then one outside the display.
    col = ($urandom_range(0, 4) != 0) ? 6'($urandom_range(1, 40)) : 6'($urandom_range(0, 63));
    issue(func, 8'($urandom), 1'($urandom_range(0, 1)), col);
  endtask

  // Registers change only with the block idle and every predicted word delivered.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
    finish_sequence();
    while (words_checked < words_taken) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SETTLE_WAIT: settle_us = value[7:0];
      CFG_CLEAR_WAIT:  clear_us = value[11:0];
      CFG_POWER_WAIT:  power_us = value;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic set_waits(input logic [15:0] settle, input logic [15:0] clear,
                           input logic [15:0] power);
    write_reg(CFG_SETTLE_WAIT, settle);
    write_reg(CFG_CLEAR_WAIT, clear);
    write_reg(CFG_POWER_WAIT, power);
  endtask

  initial begin : stimulus
    int start;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Commands before power-up run at the reset waits, with the pins left released.
    issue(FUNC_INSTR, 8'h00, 1'b0, 6'd1);
    issue(FUNC_TICK, 8'h5A, 1'b0, 6'd0);
    issue(FUNC_SPARE, 8'hA5, 1'b1, 6'd63);

    // Shortest waits, and cursor addresses with column zero wrapping below both line bases.
    set_waits(16'd1, 16'd1, 16'd1);
    issue(FUNC_INSTR, 8'h0F, 1'b0, 6'd1);
    issue(FUNC_CHAR, 8'h00, 1'b0, 6'd1);
    issue(FUNC_CHAR, 8'hA5, 1'b0, 6'd1);
    issue(FUNC_POSITION, 8'h00, 1'b0, 6'd1);
    issue(FUNC_POSITION, 8'h00, 1'b1, 6'd40);
    issue(FUNC_POSITION, 8'h00, 1'b0, 6'd0);
    issue(FUNC_POSITION, 8'h00, 1'b1, 6'd0);
    issue(FUNC_POSITION, 8'h00, 1'b1, 6'd63);
    issue(FUNC_HOME, 8'h00, 1'b0, 6'd1);
    issue(FUNC_CLEAR, 8'h00, 1'b0, 6'd1);

    // Waits written as zero still last one tick.
    set_waits(16'd0, 16'd0, 16'd0);
    issue(FUNC_CHAR, 8'h5A, 1'b1, 6'd1);
    issue(FUNC_HOME, 8'h00, 1'b0, 6'd1);
    issue(FUNC_CLEAR, 8'h00, 1'b0, 6'd1);

    // Random commands from idle with random ticks between them, at short random waits.
    for (int phase = 0; phase < 4; phase++) begin
      set_waits(16'($urandom_range(0, 4)), 16'($urandom_range(0, 24)),
                16'($urandom_range(0, 65535)));
      if (phase == 1) long_hold_ask = 1'b1;
      start = words_pushed;
      while (words_pushed - start < RAND_PHASE_WORDS) random_command();
    end

    // Longest waits. Power-up starts and the long hold-off lands on its first wait,
    // while ticks keep coming and some of them carry commands that must be refused.
    set_waits(16'd255, 16'd4095, 16'd65535);
    long_hold_ask = 1'b1;
    start_power_up();
    repeat (FINAL_IDLING_WORDS) send_word(filler_word());

    // No idling on either side from here on.
    idling_on = 1'b0;
    repeat (FINAL_STEADY_WORDS) send_word(filler_word());

    while (words_pushed != words_taken) @(posedge clk);
    while (words_checked < words_taken) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_pins.size() != 0) begin
      $error("%0d predicted output words never arrived", expected_pins.size());
      mismatch_count++;
    end
    $display("Covered %0d tick words: %0d commands from idle, %0d refused while busy,",
             words_taken, cmds_sent, refused_count);
    $display("%0d power-up starts and %0d register writes from zero waits up to the maxima.",
             powerups, reg_writes);
    if (mismatch_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // Backstop against a hung handshake; far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/clcd_pkg.sv
sv/clcd_front.sv
sv/clcd_queue.sv
sv/clcd_back.sv
sv/char_lcd_4bit_interface_sequencer.sv
verif/char_lcd_4bit_interface_sequencer_tb.sv
